// ===== hdl/tofj_pkg.sv =====
`timescale 1ns / 1ps

package tofj_pkg;

  // Payload widths
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordsW    = 4;
  localparam int unsigned VerdictW  = 3;
  localparam int unsigned OffsetW   = 6;
  localparam int unsigned SubtypeW  = 4;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 8;

  // Fixed TCP header part and option byte codes
  localparam logic [OffsetW-1:0] BaseHeaderBytes = 6'd20;
  localparam logic [WordsW-1:0]  MinHeaderWords  = 4'd5;
  localparam logic [ByteW-1:0]   KindEol         = 8'd0;
  localparam logic [ByteW-1:0]   KindNop         = 8'd1;
  localparam logic [ByteW-1:0]   MinOptionLen    = 8'd2;

  // Configuration reset values
  localparam logic [ByteW-1:0]    MultipathKindReset = 8'd30;
  localparam logic [SubtypeW-1:0] JoinSubtypeReset   = 4'd1;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_MULTIPATH_KIND = 1'b0,
    CFG_JOIN_SUBTYPE   = 1'b1
  } cfg_index_t;

  // Walk phase
  typedef enum logic [2:0] {
    PH_DONE,
    PH_KIND,
    PH_LEN,
    PH_SUB,
    PH_SKIP
  } phase_t;

  // Verdict codes
  typedef enum logic [VerdictW-1:0] {
    V_JOIN      = 3'd0,
    V_EOL       = 3'd1,
    V_BAD_LEN   = 3'd2,
    V_TRUNCATED = 3'd3,
    V_EXHAUSTED = 3'd4
  } verdict_t;

  // One result item
  typedef struct packed {
    verdict_t             verdict;
    logic [OffsetW-1:0]   option_offset;
  } result_t;

endpackage

// ===== hdl/tofj_if.sv =====
`timescale 1ns / 1ps

// Option byte channel
interface tofj_in_if;
  logic                              valid;
  logic                              ready;
  logic [tofj_pkg::ByteW-1:0]        data_byte;
  logic                              first_item;
  logic [tofj_pkg::WordsW-1:0]       header_words;

  modport source (output valid, data_byte, first_item, header_words, input ready);
  modport sink   (input valid, data_byte, first_item, header_words, output ready);
endinterface

// Verdict channel
interface tofj_out_if;
  logic                              valid;
  logic                              ready;
  logic [tofj_pkg::VerdictW-1:0]     verdict;
  logic [tofj_pkg::OffsetW-1:0]      option_offset;

  modport source (output valid, verdict, option_offset, input ready);
  modport sink   (input valid, verdict, option_offset, output ready);
endinterface

// ===== hdl/tcp_option_join_finder_top.sv =====
`timescale 1ns / 1ps

// TCP option join finder.
// The opt channel carries the options area one byte per transfer; first_item
// marks the first byte of a header and carries its data offset in words.
// The result channel gives one verdict per header: the offset of the first
// join option of the configured multipath kind, end-of-list, bad length,
// truncated option or area exhausted. Bytes after a verdict are dropped
// until the next first_item.
// Configuration: cfg_we with cfg_index 0 writes the multipath kind, index 1
// the join subtype; write only while the block is idle.
// Throughput: one byte per cycle while the skid stage is empty. The walk
// state updates in the cycle of the transfer; a verdict goes to the result
// register, or to the skid stage while the result register is full.
// A result register plus a one-entry skid stage decouple the channels: the
// block keeps taking bytes while one verdict waits, and stops only when both
// stages are full.
// Reset (synchronous, active high) empties both stages, returns the walk to
// waiting for a first item and loads kind 30 and subtype 1.
module tcp_option_join_finder_top (
  input  logic                               clk,
  input  logic                               rst,
  tofj_in_if.sink                            opt,
  tofj_out_if.source                         result,
  input  logic                               cfg_we,
  input  logic [tofj_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [tofj_pkg::CfgDataW-1:0]      cfg_data
);

  // Configuration registers
  logic [tofj_pkg::ByteW-1:0]    multipath_kind;
  logic [tofj_pkg::SubtypeW-1:0] join_subtype;

  // Walk state
  tofj_pkg::phase_t              phase, phase_next;
  logic [tofj_pkg::OffsetW-1:0]  bytes_left, bytes_left_next;
  logic [tofj_pkg::OffsetW-1:0]  skip_left, skip_left_next;
  logic [tofj_pkg::OffsetW-1:0]  byte_pos, byte_pos_next;
  logic [tofj_pkg::OffsetW-1:0]  opt_start, opt_start_next;
  logic                          kind_match, kind_match_next;

  // Working values after a possible restart
  tofj_pkg::phase_t              ph;
  logic [tofj_pkg::OffsetW-1:0]  bl;
  logic [tofj_pkg::OffsetW-1:0]  bl_dec;
  logic [tofj_pkg::OffsetW-1:0]  sk;
  logic [tofj_pkg::OffsetW-1:0]  sk_dec;
  logic [tofj_pkg::OffsetW-1:0]  area_bytes;

  logic                          take;
  logic                          res_valid;
  tofj_pkg::result_t             res;

  // Output register and skid stage
  logic                          o_valid, s_valid;
  tofj_pkg::result_t             o_data, s_data;
  logic                          pop;

  assign take      = opt.valid & opt.ready;
  assign opt.ready = ~s_valid;
  assign pop       = o_valid & result.ready;

  // Area length from the data offset
  assign area_bytes = (opt.header_words >= tofj_pkg::MinHeaderWords)
                    ? ({opt.header_words, 2'b00} - tofj_pkg::BaseHeaderBytes)
                    : '0;

  // Step the walk by one byte
  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    skip_left_next  = skip_left;
    byte_pos_next   = byte_pos;
    opt_start_next  = opt_start;
    kind_match_next = kind_match;
    res_valid       = 1'b0;
    res.verdict     = tofj_pkg::V_EXHAUSTED;
    res.option_offset = '0;
    ph = phase;
    bl = bytes_left;
    sk = skip_left;

    // Restart on a first byte
    if (opt.first_item) begin
      bl              = area_bytes;
      sk              = '0;
      bytes_left_next = area_bytes;
      skip_left_next  = '0;
      byte_pos_next   = '0;
      opt_start_next  = '0;
      kind_match_next = 1'b0;
      if (area_bytes == '0) begin
        ph        = tofj_pkg::PH_DONE;
        res_valid = 1'b1;
      end else begin
        ph = tofj_pkg::PH_KIND;
      end
      phase_next = ph;
    end

    bl_dec = (bl != '0) ? bl - 1'b1 : bl;
    sk_dec = (sk != '0) ? sk - 1'b1 : sk;

    case (ph)
      tofj_pkg::PH_KIND: begin
        if (opt.data_byte == tofj_pkg::KindEol) begin
          phase_next  = tofj_pkg::PH_DONE;
          res_valid   = 1'b1;
          res.verdict = tofj_pkg::V_EOL;
        end else if (opt.data_byte == tofj_pkg::KindNop) begin
          byte_pos_next   = byte_pos_next + 1'b1;
          bytes_left_next = bl_dec;
          phase_next      = tofj_pkg::PH_KIND;
          if (bl_dec == '0) begin
            phase_next = tofj_pkg::PH_DONE;
            res_valid  = 1'b1;
          end
        end else if (bl <= 6'd1) begin
          phase_next  = tofj_pkg::PH_DONE;
          res_valid   = 1'b1;
          res.verdict = tofj_pkg::V_TRUNCATED;
        end else begin
          kind_match_next = (opt.data_byte == multipath_kind);
          opt_start_next  = byte_pos_next;
          byte_pos_next   = byte_pos_next + 1'b1;
          bytes_left_next = bl_dec;
          phase_next      = tofj_pkg::PH_LEN;
        end
      end
      tofj_pkg::PH_LEN: begin
        if (opt.data_byte < tofj_pkg::MinOptionLen) begin
          phase_next  = tofj_pkg::PH_DONE;
          res_valid   = 1'b1;
          res.verdict = tofj_pkg::V_BAD_LEN;
        end else if ({1'b0, opt.data_byte} > ({3'b000, bl} + 9'd1)) begin
          phase_next  = tofj_pkg::PH_DONE;
          res_valid   = 1'b1;
          res.verdict = tofj_pkg::V_TRUNCATED;
        end else begin
          skip_left_next  = opt.data_byte[tofj_pkg::OffsetW-1:0] - 6'd2;
          byte_pos_next   = byte_pos + 1'b1;
          bytes_left_next = bl_dec;
          if (skip_left_next == '0) begin
            phase_next = tofj_pkg::PH_KIND;
            if (bl_dec == '0) begin
              phase_next = tofj_pkg::PH_DONE;
              res_valid  = 1'b1;
            end
          end else begin
            phase_next = kind_match ? tofj_pkg::PH_SUB : tofj_pkg::PH_SKIP;
          end
        end
      end
      tofj_pkg::PH_SUB,
      tofj_pkg::PH_SKIP: begin
        if (ph == tofj_pkg::PH_SUB && opt.data_byte[7:4] == join_subtype) begin
          phase_next        = tofj_pkg::PH_DONE;
          res_valid         = 1'b1;
          res.verdict       = tofj_pkg::V_JOIN;
          res.option_offset = opt_start;
        end else begin
          skip_left_next  = sk_dec;
          byte_pos_next   = byte_pos + 1'b1;
          bytes_left_next = bl_dec;
          if (sk_dec == '0) begin
            phase_next = tofj_pkg::PH_KIND;
            if (bl_dec == '0) begin
              phase_next = tofj_pkg::PH_DONE;
              res_valid  = 1'b1;
            end
          end else begin
            phase_next = tofj_pkg::PH_SKIP;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      multipath_kind <= tofj_pkg::MultipathKindReset;
      join_subtype   <= tofj_pkg::JoinSubtypeReset;
    end else if (cfg_we) begin
      case (cfg_index)
        tofj_pkg::CFG_MULTIPATH_KIND: multipath_kind <= cfg_data;
        tofj_pkg::CFG_JOIN_SUBTYPE:   join_subtype <= cfg_data[tofj_pkg::SubtypeW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Advance the walk on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= tofj_pkg::PH_DONE;
      bytes_left <= '0;
      skip_left  <= '0;
      byte_pos   <= '0;
      opt_start  <= '0;
      kind_match <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      skip_left  <= skip_left_next;
      byte_pos   <= byte_pos_next;
      opt_start  <= opt_start_next;
      kind_match <= kind_match_next;
    end
  end

  // Result register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (!o_valid || pop) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        s_valid <= 1'b0;
      end else begin
        o_valid <= take & res_valid;
      end
    end else if (take && res_valid) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || pop) begin
      o_data <= s_valid ? s_data : res;
    end
    if (o_valid && !pop && !s_valid) begin
      s_data <= res;
    end
  end

  assign result.valid         = o_valid;
  assign result.verdict       = o_data.verdict;
  assign result.option_offset = o_data.option_offset;

endmodule
